// File: rtl/kt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kt_pkg;

  // Board geometry. Coordinates on the ports stay 3 bits wide for every size.
  localparam int BoardSize = 8;
  localparam int CoordW    = $clog2(BoardSize);
  localparam int Total     = BoardSize * BoardSize;
  localparam int CntW      = $clog2(Total + 1);
  localparam int StepW     = 6;
  localparam int PosW      = CoordW + 2;
  localparam int NumMoves  = 8;
  localparam int DegW      = 4;

  // Degree value that no real candidate can reach: no square chosen yet.
  localparam logic [DegW-1:0] NoChoice = DegW'(9);

  typedef logic signed [PosW-1:0] pos_t;

  // Knight moves in the fixed search order.
  localparam logic signed [2:0] MoveDr [NumMoves] =
    '{3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1, 3'sd1, 3'sd2};
  localparam logic signed [2:0] MoveDc [NumMoves] =
    '{3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1};

  function automatic logic on_board(pos_t v);
    return !v[PosW-1] && (v < pos_t'(BoardSize));
  endfunction

  typedef struct packed {
    logic load_start;
    logic clear_row;
    logic emit_start;
    logic move_init;
    logic start_cand;
    logic next_cand;
    logic rd_issue;
    logic acc;
    logic decide;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic off_board;
    logic cand_ok;
    logic k_last;
    logic i_last;
    logic no_choice;
    logic tour_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/kt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] start_row;
  logic [2:0] start_col;

  modport source (output valid, output start_row, output start_col, input ready);
  modport sink   (input valid, input start_row, input start_col, output ready);
endinterface

interface kt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] row;
  logic [2:0] col;
  logic [5:0] step;
  logic       failed;
  logic       last;

  modport source (output valid, output row, output col, output step, output failed,
                  output last, input ready);
  modport sink   (input valid, input row, input col, input step, input failed,
                  input last, output ready);
endinterface

`default_nettype wire

// File: rtl/kt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire kt_pkg::sts_t  sts_i,
  output kt_pkg::cmd_t       cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CLEAR     = 9'b000000010,
    S_START     = 9'b000000100,
    S_MOVE_INIT = 9'b000001000,
    S_CAND      = 9'b000010000,
    S_RD        = 9'b000100000,
    S_ACC       = 9'b001000000,
    S_DECIDE    = 9'b010000000,
    S_COMMIT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_start = 1'b1;
          state_d          = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_row = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (sts_i.out_free) begin
          cmd_o.emit_start = 1'b1;
          state_d          = sts_i.off_board ? S_IDLE : S_MOVE_INIT;
        end
      end
      S_MOVE_INIT: begin
        cmd_o.move_init = 1'b1;
        state_d         = S_CAND;
      end
      S_CAND: begin
        if (sts_i.cand_ok) begin
          cmd_o.start_cand = 1'b1;
          state_d          = S_RD;
        end else if (sts_i.i_last) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.next_cand = 1'b1;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.k_last ? S_DECIDE : S_RD;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.i_last) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.next_cand = 1'b1;
          state_d         = S_CAND;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = (sts_i.no_choice || sts_i.tour_done) ? S_IDLE : S_MOVE_INIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/kt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module kt_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [2:0]    start_row_i,
  input  wire logic [2:0]    start_col_i,
  input  wire kt_pkg::cmd_t  cmd_i,
  output kt_pkg::sts_t       sts_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [2:0]         out_row_o,
  output logic [2:0]         out_col_o,
  output logic [5:0]         out_step_o,
  output logic               out_failed_o,
  output logic               out_last_o
);

  localparam int BoardSize = kt_pkg::BoardSize;
  localparam int CoordW    = kt_pkg::CoordW;
  localparam int CntW      = kt_pkg::CntW;
  localparam int DegW      = kt_pkg::DegW;

  // Visited map, one row of squares per word.
  logic [BoardSize-1:0] mem_q [BoardSize];
  logic [BoardSize-1:0] rd_word_q;

  logic [2:0]           sr_q, sc_q;
  logic [CoordW-1:0]    clr_cnt_q;
  logic [CoordW-1:0]    cur_row_q, cur_col_q;
  logic [CntW-1:0]      step_cnt_q;
  logic [2:0]           i_q;
  logic [2:0]           k_q;
  logic [DegW-1:0]      cnt_q, best_q;
  logic                 cand_free_q;
  logic [BoardSize-1:0] cand_word_q, best_word_q;
  logic [CoordW-1:0]    br_q, bc_q;

  logic                 out_valid_q;
  logic [2:0]           out_row_q, out_col_q;
  logic [5:0]           out_step_q;
  logic                 out_failed_q, out_last_q;

  kt_pkg::pos_t nr, nc, wr, d_off;
  logic         row_ok, off_board, out_free, tour_done, last_move;
  logic [DegW-1:0] add_cnt;

  logic                 mem_we;
  logic [CoordW-1:0]    mem_wa;
  logic [BoardSize-1:0] mem_wd;

  assign nr = kt_pkg::pos_t'(cur_row_q) + kt_pkg::pos_t'(kt_pkg::MoveDr[i_q]);
  assign nc = kt_pkg::pos_t'(cur_col_q) + kt_pkg::pos_t'(kt_pkg::MoveDc[i_q]);
  // Rows of the onward squares lie from two above to two below the candidate.
  assign d_off  = kt_pkg::pos_t'(k_q) - kt_pkg::pos_t'(2);
  assign wr     = nr + d_off;
  assign row_ok = kt_pkg::on_board(wr);

  assign off_board = ({1'b0, sr_q} >= (CoordW + 1)'(BoardSize)) ||
                     ({1'b0, sc_q} >= (CoordW + 1)'(BoardSize));
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_move = ({1'b0, step_cnt_q} + (CntW + 1)'(1)) >= (CntW + 1)'(kt_pkg::Total);
  assign tour_done = last_move;

  always_comb begin
    add_cnt = '0;
    for (int j = 0; j < kt_pkg::NumMoves; j++) begin
      kt_pkg::pos_t c;
      c = nc + kt_pkg::pos_t'(kt_pkg::MoveDc[j]);
      if ((kt_pkg::pos_t'(kt_pkg::MoveDr[j]) == d_off) && row_ok && kt_pkg::on_board(c) &&
          !rd_word_q[c[CoordW-1:0]]) begin
        add_cnt = add_cnt + DegW'(1);
      end
    end
  end

  always_comb begin
    sts_o.clear_done = (clr_cnt_q == CoordW'(BoardSize - 1));
    sts_o.off_board  = off_board;
    sts_o.cand_ok    = kt_pkg::on_board(nr) && kt_pkg::on_board(nc);
    sts_o.k_last     = (k_q == 3'd4);
    sts_o.i_last     = (i_q == 3'(kt_pkg::NumMoves - 1));
    sts_o.no_choice  = (best_q == kt_pkg::NoChoice);
    sts_o.tour_done  = tour_done;
    sts_o.out_free   = out_free;
  end

  // One write port: row clear, start mark, or mark of the chosen square.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_q;
    mem_wd = '0;
    if (cmd_i.clear_row) begin
      mem_we = 1'b1;
    end else if (cmd_i.emit_start && !off_board) begin
      mem_we = 1'b1;
      mem_wa = sr_q[CoordW-1:0];
      mem_wd = BoardSize'(1) << sc_q[CoordW-1:0];
    end else if (cmd_i.commit && (best_q != kt_pkg::NoChoice)) begin
      mem_we = 1'b1;
      mem_wa = br_q;
      mem_wd = best_word_q | (BoardSize'(1) << bc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_issue) begin
      rd_word_q <= mem_q[wr[CoordW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      sr_q      <= start_row_i;
      sc_q      <= start_col_i;
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_row) begin
      clr_cnt_q <= clr_cnt_q + CoordW'(1);
    end

    if (cmd_i.emit_start) begin
      cur_row_q  <= sr_q[CoordW-1:0];
      cur_col_q  <= sc_q[CoordW-1:0];
      step_cnt_q <= CntW'(1);
    end else if (cmd_i.commit && (best_q != kt_pkg::NoChoice)) begin
      cur_row_q  <= br_q;
      cur_col_q  <= bc_q;
      step_cnt_q <= step_cnt_q + CntW'(1);
    end

    if (cmd_i.move_init) begin
      i_q    <= '0;
      best_q <= kt_pkg::NoChoice;
    end else if (cmd_i.next_cand) begin
      i_q <= i_q + 3'd1;
    end

    if (cmd_i.start_cand) begin
      k_q         <= '0;
      cnt_q       <= '0;
      cand_free_q <= 1'b0;
    end else if (cmd_i.acc) begin
      k_q   <= k_q + 3'd1;
      cnt_q <= cnt_q + add_cnt;
      if (d_off == kt_pkg::pos_t'(0)) begin
        cand_free_q <= !rd_word_q[nc[CoordW-1:0]];
        cand_word_q <= rd_word_q;
      end
    end

    if (cmd_i.decide && cand_free_q && (cnt_q < best_q)) begin
      best_q      <= cnt_q;
      br_q        <= nr[CoordW-1:0];
      bc_q        <= nc[CoordW-1:0];
      best_word_q <= cand_word_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_start || cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      if (off_board) begin
        out_row_q    <= '0;
        out_col_q    <= '0;
        out_failed_q <= 1'b1;
        out_last_q   <= 1'b1;
      end else begin
        out_row_q    <= sr_q;
        out_col_q    <= sc_q;
        out_failed_q <= 1'b0;
        out_last_q   <= (kt_pkg::Total <= 1);
      end
      out_step_q <= '0;
    end else if (cmd_i.commit) begin
      if (best_q == kt_pkg::NoChoice) begin
        out_row_q    <= '0;
        out_col_q    <= '0;
        out_failed_q <= 1'b1;
        out_last_q   <= 1'b1;
      end else begin
        out_row_q    <= 3'(br_q);
        out_col_q    <= 3'(bc_q);
        out_failed_q <= 1'b0;
        out_last_q   <= last_move;
      end
      out_step_q <= step_cnt_q[5:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_step_o   = out_step_q;
  assign out_failed_o = out_failed_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

// File: rtl/knight_tour_warnsdorff_top.sv
// Knight's tour generator using Warnsdorff's rule.
// The input channel carries one start square per transaction (start_row,
// start_col). Each accepted transaction starts a tour: the visited map is
// cleared, the start square is marked and sent out as step 0, and then each
// chosen square follows in visit order on the output channel. The final
// result of a tour carries last; a dead end ends the tour with one result
// that has failed and last set and row and column zero.
// The visited map is an 8-word memory, one word per board row, with a
// registered read. It is cleared one row at a time before the start square
// is sent out. Each move scans the eight candidate squares; a candidate off
// the board is skipped without any read, and for one on the board the five
// rows around it are read and counted in turn, one row after the other.
// A new start square is taken only when the previous tour has finished.
// The output is a register, so the last result of a tour may wait to be
// taken while the next start square is already accepted. When the receiver
// stalls, the engine holds before writing the next result, and no result is
// dropped or repeated. Reset returns the engine to idle and empties the
// output register; the map needs no reset since every tour clears it.
`timescale 1ns / 1ps
`default_nettype none

module knight_tour_warnsdorff_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kt_in_if.sink     in_i,
  kt_out_if.source  out_o
);

  kt_pkg::cmd_t cmd;
  kt_pkg::sts_t sts;

  kt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_row_i  (in_i.start_row),
    .start_col_i  (in_i.start_col),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_row_o    (out_o.row),
    .out_col_o    (out_o.col),
    .out_step_o   (out_o.step),
    .out_failed_o (out_o.failed),
    .out_last_o   (out_o.last)
  );

endmodule

`default_nettype wire

// File: tb/knight_tour_warnsdorff_top_tb.sv
`timescale 1ns / 1ps

// Testbench for the Warnsdorff knight's tour generator.
// Every start square that the input channel accepts is handed to a tour
// planner in this file. The planner walks the same tour on its own copy of
// the visited map. It appends each square that the block should send, in
// visit order, to a queue. A checker on the output channel takes the oldest
// queued square for each output transaction and compares it field by field.
module knight_tour_warnsdorff_top_tb;

  // The drain limit covers one tour of engine work plus a stall on each of
  // its results. The tail leaves room for any extra result from the block to
  // show up.
  localparam int DrainLimit  = 20000;
  localparam int TailCycles  = 200;
  localparam int LongHold    = 5000;
  localparam int DegreeNone  = 9;
  localparam int MaxReported = 50;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic [5:0] step;
    logic       failed;
    logic       last;
  } tour_square_t;

  // Knight offsets in the search order. The first candidate wins a tie.
  localparam int KnightDr [8] = '{2, 1, -1, -2, -2, -1, 1, 2};
  localparam int KnightDc [8] = '{1, 2, 2, 1, -1, -2, -2, -1};

  logic clk_i;
  logic rst_ni;

  kt_in_if  in_if ();
  kt_out_if out_if ();

  knight_tour_warnsdorff_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tour_square_t pending_squares [$];
  int           mismatch_count;

  // These flags control idling on each side. The long hold is requested
  // once, by the back-pressure test.
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_go;
  bit rx_hold;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxReported) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic bit square_open(input logic [63:0] seen, input int r, input int c);
    if (r < 0 || r >= kt_pkg::BoardSize || c < 0 || c >= kt_pkg::BoardSize) begin
      return 1'b0;
    end
    return !seen[r * 8 + c];
  endfunction

  function automatic void push_square(input int r, input int c, input int st,
                                      input bit fail, input bit fin);
    tour_square_t sq;
    sq.row    = r[2:0];
    sq.col    = c[2:0];
    sq.step   = st[5:0];
    sq.failed = fail;
    sq.last   = fin;
    pending_squares.push_back(sq);
  endfunction

  // This function plans the whole tour from one start square. It queues
  // every result in order. A dead end queues one failure result, which
  // carries the number of squares visited so far.
  function automatic void plan_tour(input logic [2:0] sr, input logic [2:0] sc);
    logic [63:0] seen;
    int          r, c, nr, nc, br, bc;
    int          visited, best, degree;
    seen = '0;
    if (int'(sr) >= kt_pkg::BoardSize || int'(sc) >= kt_pkg::BoardSize) begin
      push_square(0, 0, 0, 1'b1, 1'b1);
      return;
    end
    r = sr;
    c = sc;
    seen[r * 8 + c] = 1'b1;
    visited = 1;
    push_square(r, c, 0, 1'b0, kt_pkg::Total <= 1);
    while (visited < kt_pkg::Total) begin
      best = DegreeNone;
      br = 0;
      bc = 0;
      for (int i = 0; i < 8; i++) begin
        nr = r + KnightDr[i];
        nc = c + KnightDc[i];
        if (!square_open(seen, nr, nc)) continue;
        degree = 0;
        for (int j = 0; j < 8; j++) begin
          if (square_open(seen, nr + KnightDr[j], nc + KnightDc[j])) degree++;
        end
        // The comparison is strict, so an equal degree keeps the earlier
        // candidate.
        if (degree < best) begin
          best = degree;
          br = nr;
          bc = nc;
        end
      end
      if (best == DegreeNone) begin
        push_square(0, 0, visited, 1'b1, 1'b1);
        return;
      end
      seen[br * 8 + bc] = 1'b1;
      r = br;
      c = bc;
      push_square(br, bc, visited, 1'b0, visited + 1 >= kt_pkg::Total);
      visited++;
    end
  endfunction

  // This task offers one start square. It may insert a random gap before the
  // square. The inputs change only at the falling edge. Valid stays high
  // after the transaction, so a back-to-back item gets a single assignment.
  // The caller lowers valid once the stimulus is done.
  task automatic offer_start(input logic [2:0] r, input logic [2:0] c);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.start_row <= r;
    in_if.start_col <= c;
    @(posedge clk_i);
    while (!(in_if.valid && in_if.ready)) @(posedge clk_i);
    plan_tour(r, c);
  endtask

  // Output side. Ready is low during the long hold and during random stall
  // bursts. Otherwise it is high.
  initial begin : sink_side
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 15) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // The long receiver hold is counted here, in rising edges. The flag
  // changes at a rising edge, so the sink process reads a stable value at
  // the next falling edge.
  initial begin : long_hold
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (LongHold) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Checker. Every output transaction must match the oldest planned square.
  always @(posedge clk_i) begin : result_check
    tour_square_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_squares.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d step %0d",
                                  out_if.row, out_if.col, out_if.step));
      end else begin
        want = pending_squares.pop_front();
        if (out_if.row !== want.row)
          report_mismatch($sformatf("row got %0d want %0d at step %0d",
                                    out_if.row, want.row, want.step));
        if (out_if.col !== want.col)
          report_mismatch($sformatf("col got %0d want %0d at step %0d",
                                    out_if.col, want.col, want.step));
        if (out_if.step !== want.step)
          report_mismatch($sformatf("step got %0d want %0d",
                                    out_if.step, want.step));
        if (out_if.failed !== want.failed)
          report_mismatch($sformatf("failed got %b want %b at step %0d",
                                    out_if.failed, want.failed, want.step));
        if (out_if.last !== want.last)
          report_mismatch($sformatf("last got %b want %b at step %0d",
                                    out_if.last, want.last, want.step));
      end
    end
  end

  // The four corners give the extreme values of both coordinates.
  task automatic test_corner_starts();
    offer_start(3'd0, 3'd0);
    offer_start(3'd0, 3'd7);
    offer_start(3'd7, 3'd0);
    offer_start(3'd7, 3'd7);
  endtask

  // These squares lie on the edges of the board. Close to an edge, many
  // candidates fall off the board.
  task automatic test_edge_starts();
    offer_start(3'd0, 3'd3);
    offer_start(3'd3, 3'd0);
    offer_start(3'd7, 3'd4);
    offer_start(3'd4, 3'd7);
    offer_start(3'd0, 3'd5);
    offer_start(3'd6, 3'd7);
  endtask

  // From these central squares all eight candidates are on the board.
  task automatic test_center_starts();
    offer_start(3'd3, 3'd3);
    offer_start(3'd4, 3'd4);
    offer_start(3'd2, 3'd5);
    offer_start(3'd5, 3'd2);
  endtask

  // Every square is started once, in shuffled order. Any start that runs
  // into a dead end is therefore reached.
  task automatic test_square_sweep();
    int order [64];
    int k, tmp;
    for (int i = 0; i < 64; i++) order[i] = i;
    for (int i = 63; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    foreach (order[i]) offer_start(3'(order[i] / 8), 3'(order[i] % 8));
  endtask

  // The receiver holds off for a long stretch from the start of a tour, and
  // the sender keeps offering start squares. The engine must stall behind
  // the full output register, and the input must stall behind the engine.
  task automatic test_output_backpressure();
    offer_start(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    hold_go = 1'b1;
    offer_start(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    offer_start(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endtask

  // Random start squares. The idling on each side is chosen anew for each
  // chunk, so some chunks may run with no idling at all.
  task automatic test_random_starts(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      offer_start(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    end
  endtask

  // The last stretch runs with no idling on either side.
  task automatic test_unpaced_stream(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < count; i++) begin
      offer_start(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin : main_sequence
    int waited;
    mismatch_count  = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    hold_go         = 1'b0;
    in_if.valid     = 1'b0;
    in_if.start_row = 3'd0;
    in_if.start_col = 3'd0;
    rst_ni          = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_starts();
    test_edge_starts();
    test_center_starts();
    test_square_sweep();
    test_output_backpressure();
    test_random_starts(340);
    test_unpaced_stream(30);

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Wait until every planned square has arrived or the drain limit is hit.
    // Then wait out the tail, so that any extra result from the block can still show up.
    waited = 0;
    while (pending_squares.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_squares.size() != 0) begin
      report_mismatch($sformatf("%0d planned squares never arrived",
                                pending_squares.size()));
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog. This is several times the slowest correct run.
  initial begin : watchdog
    #(64'd200_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
